FILE: rtl/bsde_pkg.sv
// Shared constants and codes for the de Boor B-spline evaluator.
package bsde_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int MAX_ORDER_DEF  = 8;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int COORD_W = 32;
  localparam int IDX_W   = 9;
  localparam int CFG_W   = 9;

  typedef enum logic [1:0] {
    CMD_WRITE_POINT = 2'd0,
    CMD_WRITE_KNOT  = 2'd1,
    CMD_EVALUATE    = 2'd2,
    CMD_NONE        = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SPLINE_ORDER  = 2'd0,
    REG_POINT_COUNT   = 2'd1,
    REG_UNIFORM_KNOTS = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

endpackage

FILE: rtl/bspline_de_boor_eval_top.sv
// De Boor B-spline curve evaluator: stores, span search and shared blend unit.
// Write words are stored on acceptance. An evaluate word runs the forward span search, the backward
// one when t equals the last knot, the point loads and then the blends, which share the single
// divider and multiplier.
// Throughput: one word at a time, the next taken the cycle after the result is raised; a
// result waits until the previous one has left. Reset (rst, synchronous) idles the sequencer.
module bspline_de_boor_eval_top #(
  parameter int MAX_POINTS = bsde_pkg::MAX_POINTS_DEF,
  parameter int MAX_ORDER  = bsde_pkg::MAX_ORDER_DEF,
  parameter int FRAC_BITS  = bsde_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // entry_index, point_x, point_y, point_z, scalar_value, zero fill
  input  logic [143:0] s_tdata,
  // command
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // curve_x, curve_y, curve_z, span_index, status, zero fill
  output logic [111:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [bsde_pkg::CFG_W-1:0] cfg_data
);

  localparam int CW = bsde_pkg::COORD_W;
  localparam int KD = MAX_POINTS + MAX_ORDER;
  localparam int KW = $clog2(KD + 1);
  localparam int KA = $clog2(KD);
  localparam int PA = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int OW = $clog2(MAX_ORDER + 1);
  localparam int BA = $clog2(MAX_ORDER);
  localparam int DCW = $clog2(FRAC_BITS + 1);
  localparam int PRW = CW + FRAC_BITS + 3;

  typedef enum logic [4:0] {
    S_IDLE, S_F0W, S_F0U, S_FLW, S_FLU, S_SW, S_SU, S_BW, S_BU, S_SAT,
    S_PW, S_PR, S_PU, S_LA, S_LAW, S_LAU, S_LBW, S_LBU, S_DIV, S_MUL, S_ADD, S_WR
  } state_t;

  state_t state;

  logic [3:0]   spline_order;
  logic [8:0]   point_count;
  logic         uniform_knots;

  logic [3*CW-1:0] pmem [MAX_POINTS];
  logic [CW-1:0]   kmem [KD];
  logic [3*CW-1:0] bmem [MAX_ORDER];

  logic [KW-1:0]   kaddr;
  logic [CW-1:0]   kmem_q;
  logic [PA-1:0]   paddr;
  logic [3*CW-1:0] pmem_q;
  logic [BA-1:0]   baddr_a, baddr_b;
  logic [3*CW-1:0] bmem_qa, bmem_qb;

  logic [OW-1:0]   k, d, j;
  logic [NW-1:0]   n;
  logic [KW-1:0]   m, i;
  logic signed [KW:0] r;
  logic [CW-1:0]   t, first, last, ki;
  logic [CW-1:0]   kval;
  logic [3*CW-1:0] a_v, b_v, res;
  logic [1:0]      c;
  logic [32:0]     ud, rem;
  logic [FRAC_BITS:0] al;
  logic [DCW-1:0]  dcnt;
  logic signed [PRW-1:0] prod;
  logic            flag;
  logic [3*CW-1:0] out_pt;
  logic [8:0]      out_span;
  logic            out_status;

  logic [8:0]   in_idx;
  logic [CW-1:0] in_x, in_y, in_z, in_s;
  logic [OW-1:0] k_in;
  logic [NW-1:0] n_in;
  logic [KW-1:0] gen_v;
  logic signed [33:0] num_s, den_s;
  logic [32:0] un, udn;
  logic [33:0] rem2;
  logic signed [CW:0] diff;
  logic signed [PRW-1:0] rnd;
  logic [CW-1:0] blend_c;
  logic [CW-1:0] t_clamp;

  assign in_idx = s_tdata[8:0];
  assign in_x   = s_tdata[40:9];
  assign in_y   = s_tdata[72:41];
  assign in_z   = s_tdata[104:73];
  assign in_s   = s_tdata[136:105];

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {6'b0, out_status, out_span, out_pt};

  always_comb begin
    if (spline_order < 4'd2) k_in = OW'(2);
    else if (32'(spline_order) > MAX_ORDER) k_in = OW'(MAX_ORDER);
    else k_in = OW'(spline_order);
    if (point_count < 9'd2) n_in = NW'(2);
    else if (32'(point_count) > MAX_POINTS) n_in = NW'(MAX_POINTS);
    else n_in = NW'(point_count);
  end

  always_comb begin
    if (32'(kaddr) >= 32'(n)) gen_v = KW'(n);
    else if (32'(kaddr) < 32'(k)) gen_v = KW'(k - OW'(1));
    else gen_v = kaddr;
    kval = uniform_knots ? (CW'(gen_v) << FRAC_BITS) : kmem_q;
  end

  always_comb begin
    t_clamp = (t < first) ? first : t;
    if (t_clamp > last) t_clamp = last;
  end

  always_comb begin
    num_s = $signed({2'b0, t}) - $signed({2'b0, ki});
    den_s = $signed({2'b0, kval}) - $signed({2'b0, ki});
    un    = num_s[33] ? 33'(-num_s) : num_s[32:0];
    udn   = den_s[33] ? 33'(-den_s) : den_s[32:0];
    rem2  = {rem, 1'b0};
    diff  = $signed({b_v[c*CW+CW-1], b_v[c*CW +: CW]})
          - $signed({a_v[c*CW+CW-1], a_v[c*CW +: CW]});
    rnd   = prod + PRW'(1 << (FRAC_BITS - 1));
    blend_c = a_v[c*CW +: CW] + CW'(rnd >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    kmem_q  <= kmem[kaddr[KA-1:0]];
    pmem_q  <= pmem[paddr];
    bmem_qa <= bmem[baddr_a];
    bmem_qb <= bmem[baddr_b];
    if (s_tvalid && s_tready) begin
      if (s_tuser == bsde_pkg::CMD_WRITE_POINT && 32'(in_idx) < MAX_POINTS)
        pmem[in_idx[PA-1:0]] <= {in_z, in_y, in_x};
      if (s_tuser == bsde_pkg::CMD_WRITE_KNOT && 32'(in_idx) < KD)
        kmem[in_idx[KA-1:0]] <= in_s;
    end
    if (state == S_PU) bmem[d[BA-1:0]] <= pmem_q;
    if (state == S_WR && !(j == k - OW'(1) && m_tvalid && !m_tready))
      bmem[d[BA-1:0]] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      spline_order  <= 4'd4;
      point_count   <= 9'd4;
      uniform_knots <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bsde_pkg::REG_SPLINE_ORDER:  spline_order  <= cfg_data[3:0];
          bsde_pkg::REG_POINT_COUNT:   point_count   <= cfg_data[8:0];
          bsde_pkg::REG_UNIFORM_KNOTS: uniform_knots <= cfg_data[0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tuser == bsde_pkg::CMD_EVALUATE) begin
            t     <= in_s;
            k     <= k_in;
            n     <= n_in;
            m     <= KW'(n_in) + KW'(k_in);
            flag  <= 1'b0;
            kaddr <= '0;
            state <= S_F0W;
          end
        end
        S_F0W: state <= S_F0U;
        S_F0U: begin
          first <= kval;
          kaddr <= m - KW'(1);
          state <= S_FLW;
        end
        S_FLW: state <= S_FLU;
        S_FLU: begin
          last  <= kval;
          i     <= '0;
          kaddr <= '0;
          state <= S_SW;
        end
        S_SW: begin
          t     <= t_clamp;
          state <= S_SU;
        end
        S_SU: begin
          if (i < m && kval <= t) begin
            i     <= i + KW'(1);
            kaddr <= i + KW'(1);
            state <= S_SW;
          end else begin
            r <= $signed({1'b0, i}) - (KW+1)'(1);
            if (t == last) begin
              i     <= m - KW'(1);
              kaddr <= m - KW'(1);
              state <= S_BW;
            end else begin
              state <= S_SAT;
            end
          end
        end
        S_BW: state <= S_BU;
        S_BU: begin
          if (i == '0 || kval < t) begin
            r     <= $signed({1'b0, i});
            state <= S_SAT;
          end else begin
            i     <= i - KW'(1);
            kaddr <= i - KW'(1);
            state <= S_BW;
          end
        end
        S_SAT: begin
          if (r < $signed({1'b0, KW'(k) - KW'(1)}) ||
              $signed({1'b0, KW'(n) - KW'(1)}) < $signed({1'b0, KW'(k) - KW'(1)}))
            r <= $signed({1'b0, KW'(k) - KW'(1)});
          else if (r > $signed({1'b0, KW'(n) - KW'(1)}))
            r <= $signed({1'b0, KW'(n) - KW'(1)});
          state <= S_PW;
          d     <= '0;
        end
        S_PW: begin
          paddr <= PA'(r - $signed({1'b0, KW'(k)}) + (KW+1)'(1) + $signed({1'b0, KW'(d)}));
          state <= S_PR;
        end
        S_PR: state <= S_PU;
        S_PU: begin
          // point read issued in S_PR lands now
          state <= S_PW;
          if (d == k - OW'(1)) begin
            j     <= OW'(1);
            d     <= k - OW'(1);
            state <= S_LA;
          end else begin
            d <= d + OW'(1);
          end
        end
        S_LA: begin
          kaddr   <= KW'(r - $signed({1'b0, KW'(k)}) + (KW+1)'(1) + $signed({1'b0, KW'(d)}));
          baddr_a <= BA'(d - OW'(1));
          baddr_b <= BA'(d);
          state   <= S_LAW;
        end
        S_LAW: state <= S_LAU;
        S_LAU: begin
          ki    <= kval;
          kaddr <= kaddr + KW'(k) - KW'(j);
          state <= S_LBW;
        end
        S_LBW: state <= S_LBU;
        S_LBU: begin
          a_v   <= bmem_qa;
          b_v   <= bmem_qb;
          c     <= 2'd0;
          state <= S_MUL;
          if (den_s == '0) begin
            flag <= 1'b1;
            al   <= '0;
          end else if (num_s == '0 || (num_s[33] != den_s[33])) begin
            al <= '0;
          end else if (un >= udn) begin
            al <= (FRAC_BITS+1)'(1) << FRAC_BITS;
          end else begin
            rem   <= un;
            ud    <= udn;
            al    <= '0;
            dcnt  <= DCW'(FRAC_BITS);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem2 >= {1'b0, ud}) begin
            rem <= 33'(rem2 - {1'b0, ud});
            al  <= {al[FRAC_BITS-1:0], 1'b1};
          end else begin
            rem <= rem2[32:0];
            al  <= {al[FRAC_BITS-1:0], 1'b0};
          end
          dcnt <= dcnt - DCW'(1);
          if (dcnt == DCW'(1)) state <= S_MUL;
        end
        S_MUL: begin
          prod  <= PRW'($signed({1'b0, al}) * diff);
          state <= S_ADD;
        end
        S_ADD: begin
          res[c*CW +: CW] <= blend_c;
          if (c == 2'd2) state <= S_WR;
          else begin
            c     <= c + 2'd1;
            state <= S_MUL;
          end
        end
        S_WR: begin
          if (d > j) begin
            d     <= d - OW'(1);
            state <= S_LA;
          end else if (j < k - OW'(1)) begin
            j     <= j + OW'(1);
            d     <= k - OW'(1);
            state <= S_LA;
          end else if (!m_tvalid) begin
            out_pt     <= res;
            out_span   <= 9'(r);
            out_status <= flag;
            m_tvalid   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !s_tready)
    else $error("input taken while sequencer busy");

  a_result_from_blend: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_WR))
    else $error("result raised outside final blend");

  a_div_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> dcnt != '0 && 32'(dcnt) <= FRAC_BITS)
    else $error("divider count out of range");

endmodule

FILE: verif/bspline_de_boor_eval_checker.sv
// Checker for the de Boor evaluator: predicts curve points and compares result words.
`timescale 1ns / 1ps
module bspline_de_boor_eval_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [143:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [bsde_pkg::CFG_W-1:0] cfg_data,
  output int           mismatches,
  output int           pending
);

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [8:0]  span;
    logic        zero_gap;
  } curve_pt_t;

  logic [31:0] pts [256][3];
  logic [31:0] knots [264];
  logic [3:0]  order_reg;
  logic [8:0]  count_reg;
  logic        uni_reg;
  curve_pt_t   pt_queue [$];

  initial mismatches = 0;
  initial pending = 0;

  function automatic longint knot_val(longint i, longint n, longint k);
    longint v;
    if (i < 0) return 0;
    if (uni_reg) begin
      v = (i >= n) ? n : ((i < k) ? k - 1 : i);
      return v <<< 16;
    end
    if (i >= 264) return 0;
    return longint'({32'd0, knots[i]});
  endfunction

  function automatic longint alpha_of(longint num, longint den, inout bit zf);
    longint q;
    if (den == 0) begin
      zf = 1;
      return 0;
    end
    if (num == 0 || ((num < 0) != (den < 0))) return 0;
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    q = (num <<< 16) / den;
    return (q > 65536) ? 65536 : q;
  endfunction

  function automatic curve_pt_t eval_curve(logic [31:0] tin);
    longint k, n, m, t, first, last, r, i, ii, ki, al, p;
    longint wk [8][3];
    int j, d, c;
    bit zf;
    curve_pt_t res;
    zf = 0;
    k = order_reg;
    if (k < 2) k = 2;
    if (k > 8) k = 8;
    n = count_reg;
    if (n < 2) n = 2;
    if (n > 256) n = 256;
    m = n + k;
    t = longint'({32'd0, tin});
    first = knot_val(0, n, k);
    last = knot_val(m - 1, n, k);
    if (t < first) t = first;
    if (t > last) t = last;
    i = 0;
    while (i < m && knot_val(i, n, k) <= t) i++;
    r = i - 1;
    if (t == last) begin
      for (i = m - 1; i > 0; i--)
        if (knot_val(i, n, k) < t) break;
      r = i;
    end
    if (r > n - 1) r = n - 1;
    if (r < k - 1) r = k - 1;
    for (d = 0; d < k; d++) begin
      p = r - k + 1 + d;
      for (c = 0; c < 3; c++)
        wk[d][c] = (p >= 0 && p < 256) ? longint'(signed'(pts[p][c])) : 0;
    end
    for (j = 1; j < k; j++) begin
      for (d = k - 1; d >= j; d--) begin
        ii = r - k + 1 + d;
        ki = knot_val(ii, n, k);
        al = alpha_of(t - ki, knot_val(ii + k - j, n, k) - ki, zf);
        for (c = 0; c < 3; c++)
          wk[d][c] = wk[d-1][c] + ((al * (wk[d][c] - wk[d-1][c]) + 32768) >>> 16);
      end
    end
    res.cx = wk[k-1][0][31:0];
    res.cy = wk[k-1][1][31:0];
    res.cz = wk[k-1][2][31:0];
    res.span = r[8:0];
    res.zero_gap = zf;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    curve_pt_t got, want;
    logic [8:0] idx;
    if (rst) begin
      order_reg <= 4;
      count_reg <= 4;
      uni_reg <= 0;
      pt_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (bsde_pkg::reg_idx_t'(cfg_index))
          bsde_pkg::REG_SPLINE_ORDER: order_reg <= cfg_data[3:0];
          bsde_pkg::REG_POINT_COUNT: count_reg <= cfg_data[8:0];
          bsde_pkg::REG_UNIFORM_KNOTS: uni_reg <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        idx = s_tdata[8:0];
        case (bsde_pkg::cmd_t'(s_tuser))
          bsde_pkg::CMD_WRITE_POINT: if (idx < 256) begin
            pts[idx][0] = s_tdata[40:9];
            pts[idx][1] = s_tdata[72:41];
            pts[idx][2] = s_tdata[104:73];
          end
          bsde_pkg::CMD_WRITE_KNOT: if (idx < 264) knots[idx] = s_tdata[136:105];
          bsde_pkg::CMD_EVALUATE:
            pt_queue.insert(pt_queue.size(), eval_curve(s_tdata[136:105]));
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.cx = m_tdata[31:0];
        got.cy = m_tdata[63:32];
        got.cz = m_tdata[95:64];
        got.span = m_tdata[104:96];
        got.zero_gap = m_tdata[105];
        if (pt_queue.size() == 0) begin
          report_mismatch("unexpected word", got.cx, 32'd0);
        end else begin
          want = pt_queue.pop_front();
          if (got.cx !== want.cx) report_mismatch("curve_x", got.cx, want.cx);
          if (got.cy !== want.cy) report_mismatch("curve_y", got.cy, want.cy);
          if (got.cz !== want.cz) report_mismatch("curve_z", got.cz, want.cz);
          if (got.span !== want.span) report_mismatch("span_index", got.span, want.span);
          if (got.zero_gap !== want.zero_gap)
            report_mismatch("status", got.zero_gap, want.zero_gap);
        end
      end
    end
    pending = pt_queue.size();
  end

endmodule

FILE: verif/bspline_de_boor_eval_top_test.sv
// Stimulus and verdict for the de Boor evaluator, with the checker alongside.
`timescale 1ns / 1ps
module bspline_de_boor_eval_top_test;

  localparam int SETTLE_CYCLES = 3000;
  localparam int STALL_LIMIT   = 20000;
  localparam int CFG_W         = bsde_pkg::CFG_W;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic [1:0]   s_tuser = bsde_pkg::CMD_NONE;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [111:0] m_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = bsde_pkg::REG_SPLINE_ORDER;
  logic [CFG_W-1:0] cfg_data = '0;
  int           mismatches, pending;
  int           idle_pct = 0, stall_pct = 0;
  int           quiet_cycles = 0;
  int           ord_eff = 4, cnt_eff = 4;

  always #5 clk = ~clk;

  bspline_de_boor_eval_top u_dut (.*);

  bspline_de_boor_eval_checker u_chk (.*);

  always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_word(bsde_pkg::cmd_t cmd, logic [8:0] idx, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z, logic [31:0] sv);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= {7'd0, sv, z, y, x, idx};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(bsde_pkg::reg_idx_t ri, logic [CFG_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= ri;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain;
    s_tvalid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_shape(logic [3:0] k, logic [8:0] n, logic u);
    drain();
    write_reg(bsde_pkg::REG_SPLINE_ORDER, CFG_W'(k));
    write_reg(bsde_pkg::REG_POINT_COUNT, n);
    write_reg(bsde_pkg::REG_UNIFORM_KNOTS, CFG_W'(u));
    ord_eff = (k < 2) ? 2 : (k > 8) ? 8 : k;
    cnt_eff = (n < 2) ? 2 : (n > 256) ? 256 : n;
  endtask

  function automatic logic [31:0] base_knot(int i);
    return ((i * 3) / 4) << 16;
  endfunction

  task automatic random_words(int count, int sidle, int rstall);
    int sel, ki;
    logic [31:0] tv;
    idle_pct = sidle;
    stall_pct = rstall;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        if ($urandom_range(3) == 0) tv = $urandom();
        else tv = $urandom_range(0, (cnt_eff + ord_eff + 1) << 16);
        send_word(bsde_pkg::CMD_EVALUATE, 9'($urandom()), $urandom(), $urandom(),
                  $urandom(), tv);
      end else if (sel < 80) begin
        send_word(bsde_pkg::CMD_WRITE_POINT,
                  ($urandom_range(9) == 0) ? 9'($urandom_range(511))
                                           : 9'($urandom_range(cnt_eff - 1)),
                  $urandom(), $urandom(), $urandom(), $urandom());
      end else if (sel < 95) begin
        ki = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(cnt_eff + ord_eff);
        tv = ($urandom_range(1) == 0) ? base_knot(ki) + $urandom_range(65535) : $urandom();
        send_word(bsde_pkg::CMD_WRITE_KNOT, 9'(ki), $urandom(), $urandom(), $urandom(), tv);
      end else begin
        send_word(bsde_pkg::CMD_NONE, 9'($urandom()), $urandom(), $urandom(), $urandom(),
                  $urandom());
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    for (int i = 0; i < 256; i++)
      send_word(bsde_pkg::CMD_WRITE_POINT, 9'(i), $urandom(), $urandom(), $urandom(), 0);
    for (int i = 0; i < 264; i++)
      send_word(bsde_pkg::CMD_WRITE_KNOT, 9'(i), 0, 0, 0, base_knot(i));
    set_shape(4, 4, 0);
    send_word(bsde_pkg::CMD_EVALUATE, 0, 0, 0, 0, 32'd0);
    send_word(bsde_pkg::CMD_EVALUATE, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_word(bsde_pkg::CMD_EVALUATE, 0, 0, 0, 0, 32'h0003_0000);
    send_word(bsde_pkg::CMD_EVALUATE, 0, 0, 0, 0, 32'h0005_0000);
    send_word(bsde_pkg::CMD_EVALUATE, 0, 0, 0, 0, 32'h0001_8000);
    send_word(bsde_pkg::CMD_WRITE_POINT, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_word(bsde_pkg::CMD_WRITE_POINT, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_word(bsde_pkg::CMD_EVALUATE, 0, 0, 0, 0, 32'h0000_C000);
    send_word(bsde_pkg::CMD_NONE, 9'h1FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_word(bsde_pkg::CMD_WRITE_POINT, 300, 32'h1234_5678, 0, 0, 0);
    send_word(bsde_pkg::CMD_WRITE_KNOT, 263, 0, 0, 0, 32'hFFFF_FFFF);
    send_word(bsde_pkg::CMD_WRITE_KNOT, 511, 0, 0, 0, 32'h0000_0001);
    send_word(bsde_pkg::CMD_WRITE_KNOT, 2, 0, 0, 0, 32'hFFFF_0000);
    send_word(bsde_pkg::CMD_EVALUATE, 0, 0, 0, 0, 32'h0002_0000);
    send_word(bsde_pkg::CMD_EVALUATE, 0, 0, 0, 0, 32'h0004_8000);
    send_word(bsde_pkg::CMD_WRITE_KNOT, 2, 0, 0, 0, base_knot(2));
    send_word(bsde_pkg::CMD_EVALUATE, 0, 0, 0, 0, 32'h0002_4000);

    set_shape(2, 2, 0);
    random_words(120, 0, 0);
    set_shape(8, 8, 0);
    random_words(100, 57, 0);
    set_shape(4, 16, 1);
    random_words(100, 0, 57);
    set_shape(3, 5, 0);
    random_words(75, 8, 8);
    s_tvalid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    random_words(75, 8, 8);
    set_shape(8, 256, 1);
    random_words(20, 0, 0);
    set_shape(2, 256, 0);
    random_words(20, 57, 0);
    set_shape(15, 511, 1);
    random_words(20, 0, 57);
    set_shape(0, 0, 0);
    random_words(40, 8, 8);
    set_shape(6, 10, 0);
    random_words(50, 0, 57);
    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: bspline_de_boor_eval_top.f
rtl/bsde_pkg.sv
rtl/bspline_de_boor_eval_top.sv
verif/bspline_de_boor_eval_checker.sv
verif/bspline_de_boor_eval_top_test.sv
